// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros for the page buffer controller
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every rising clock edge while out of reset
`define ASSERT_AT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("%m: assertion failed");

// checked on every rising clock edge, reset included
`define ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("%m: assertion failed");

`endif

// ----- rtl/opbc_pkg.sv -----
// ----------------------------------------------------------------------------
// opbc_pkg
// sizes, constants and the queued operation type of the page buffer controller
// ----------------------------------------------------------------------------
package opbc_pkg;

  localparam int PanelWidth  = 128;
  localparam int StoreBytes  = 1024;
  localparam int ChunkBytes  = 16;
  localparam int ChunkCount  = StoreBytes / ChunkBytes;
  localparam int QueueDepth  = 2;

  localparam int AddrW   = $clog2(StoreBytes);
  localparam int RdAddrW = $clog2(8 * PanelWidth);
  localparam int CntW    = (ChunkBytes > 1) ? $clog2(ChunkBytes) : 1;
  localparam int IdxW    = (ChunkCount > 1) ? $clog2(ChunkCount) : 1;
  localparam int QPtrW   = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int QCntW   = $clog2(QueueDepth + 1);

  // one classified word handed from the front to the back
  typedef struct packed {
    logic             is_read;
    logic             rd_ok;
    logic             wr_en;
    logic [AddrW-1:0] addr;
    logic [7:0]       data;
    logic [2:0]       bit_sel;
    logic             disp;
    logic             inv;
    logic             redraw;
    logic             unknown;
  } opbc_op_t;

endpackage

// ----- rtl/opbc_in_if.sv -----
// ----------------------------------------------------------------------------
// opbc_in_if
// input channel: stream byte writes and pixel read queries
// ----------------------------------------------------------------------------
interface opbc_in_if;
  logic       valid;
  logic       ready;
  logic       mode;
  logic [7:0] stream_byte;
  logic [6:0] pixel_column;
  logic [5:0] pixel_row;

  modport source (output valid, mode, stream_byte, pixel_column, pixel_row, input ready);
  modport sink   (input valid, mode, stream_byte, pixel_column, pixel_row, output ready);
endinterface

// ----- rtl/opbc_out_if.sv -----
// ----------------------------------------------------------------------------
// opbc_out_if
// result channel: pixel value and display status per word
// ----------------------------------------------------------------------------
interface opbc_out_if;
  logic valid;
  logic ready;
  logic pixel_lit;
  logic display_enabled;
  logic colors_inverted;
  logic redraw_request;
  logic unknown_command;

  modport source (output valid, pixel_lit, display_enabled, colors_inverted,
                  redraw_request, unknown_command, input ready);
  modport sink   (input valid, pixel_lit, display_enabled, colors_inverted,
                  redraw_request, unknown_command, output ready);
endinterface

// ----- rtl/opbc_front.sv -----
// ----------------------------------------------------------------------------
// opbc_front
// stream parser: tracks control/command/data phase, display flags and chunk
// position, and turns each accepted word into one queued operation
// ----------------------------------------------------------------------------
module opbc_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  opbc_in_if.sink            in_i,
  input  logic               clear_busy_i,
  input  logic               q_full_i,
  output logic               push_o,
  output opbc_pkg::opbc_op_t push_data_o
);
  import opbc_pkg::*;

  `include "assert_macros.svh"

  localparam logic [1:0] PhControl = 2'd0;
  localparam logic [1:0] PhCommand = 2'd1;
  localparam logic [1:0] PhData    = 2'd2;

  localparam logic [7:0] CtlCommand = 8'h00;
  localparam logic [7:0] CtlData    = 8'h40;
  localparam logic [7:0] CmdOff     = 8'hAE;
  localparam logic [7:0] CmdOn      = 8'hAF;
  localparam logic [7:0] CmdNormal  = 8'hA6;
  localparam logic [7:0] CmdInvert  = 8'hA7;
  localparam logic [7:0] CmdNop     = 8'hE3;

  logic [1:0]      phase_q, phase_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic            disp_q, disp_d;
  logic            inv_q, inv_d;
  logic            fire;
  logic [RdAddrW-1:0] rd_addr;
  opbc_op_t        op;

  assign in_i.ready = !q_full_i && !clear_busy_i;
  assign fire       = in_i.valid && in_i.ready;

  // page * width + column
  assign rd_addr = RdAddrW'(32'(in_i.pixel_row[5:3]) * PanelWidth + 32'(in_i.pixel_column));

  always_comb begin
    phase_d = phase_q;
    cnt_d   = cnt_q;
    idx_d   = idx_q;
    disp_d  = disp_q;
    inv_d   = inv_q;

    op         = '0;
    op.is_read = in_i.mode;
    op.data    = in_i.stream_byte;
    op.bit_sel = in_i.pixel_row[2:0];

    if (in_i.mode) begin
      op.addr  = AddrW'(rd_addr);
      op.rd_ok = (32'(in_i.pixel_column) < PanelWidth) && (32'(rd_addr) < StoreBytes);
    end else begin
      op.addr = AddrW'(32'(idx_q) * ChunkBytes + 32'(cnt_q));
      unique case (phase_q)
        PhCommand: begin
          phase_d = PhControl;
          unique case (in_i.stream_byte)
            CmdOff:    begin disp_d = 1'b0; op.redraw = 1'b1; end
            CmdOn:     begin disp_d = 1'b1; op.redraw = 1'b1; end
            CmdNormal: begin inv_d  = 1'b0; op.redraw = 1'b1; end
            CmdInvert: begin inv_d  = 1'b1; op.redraw = 1'b1; end
            CmdNop:    ;
            default:   op.unknown = 1'b1;
          endcase
        end
        PhData: begin
          op.wr_en = (32'(idx_q) * ChunkBytes + 32'(cnt_q)) < StoreBytes;
          if (cnt_q == CntW'(ChunkBytes - 1)) begin
            cnt_d   = '0;
            phase_d = PhControl;
            if (idx_q == IdxW'(ChunkCount - 1)) begin
              idx_d     = '0;
              op.redraw = 1'b1;
            end else begin
              idx_d = idx_q + 1'b1;
            end
          end else begin
            cnt_d = cnt_q + 1'b1;
          end
        end
        default: begin
          // control byte, unused phase code lands here too
          phase_d = PhControl;
          if (in_i.stream_byte == CtlCommand) begin
            phase_d = PhCommand;
          end else if (in_i.stream_byte == CtlData) begin
            phase_d = PhData;
            cnt_d   = '0;
          end
        end
      endcase
    end

    op.disp = disp_d;
    op.inv  = inv_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhControl;
      cnt_q   <= '0;
      idx_q   <= '0;
      disp_q  <= 1'b0;
      inv_q   <= 1'b0;
    end else if (fire) begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      idx_q   <= idx_d;
      disp_q  <= disp_d;
      inv_q   <= inv_d;
    end
  end

  assign push_o      = fire;
  assign push_data_o = op;

  `ASSERT_AT(a_no_accept_while_clearing, clk_i, rst_ni, clear_busy_i |-> !fire)
  `ASSERT_AT(a_chunk_count_idle, clk_i, rst_ni, (phase_q != PhData) |-> (cnt_q == '0))

endmodule

// ----- rtl/opbc_queue.sv -----
// ----------------------------------------------------------------------------
// opbc_queue
// short fifo of classified operations between parser and store
// ----------------------------------------------------------------------------
module opbc_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  opbc_pkg::opbc_op_t push_data_i,
  output logic               full_o,
  input  logic               pop_i,
  output logic               valid_o,
  output opbc_pkg::opbc_op_t pop_data_o
);
  import opbc_pkg::*;

  `include "assert_macros.svh"

  opbc_op_t         slot_q [QueueDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0] count_q;

  assign full_o     = (count_q == QCntW'(QueueDepth));
  assign valid_o    = (count_q != '0);
  assign pop_data_o = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == QPtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == QPtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  `ASSERT_AT(a_no_push_when_full, clk_i, rst_ni, full_o |-> !push_i)
  `ASSERT_AT(a_no_pop_when_empty, clk_i, rst_ni, !valid_o |-> !pop_i)

endmodule

// ----- rtl/opbc_back.sv -----
// ----------------------------------------------------------------------------
// opbc_back
// frame store with clear sweep; executes queued writes and reads and holds
// the result word until it is taken
// ----------------------------------------------------------------------------
module opbc_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               q_valid_i,
  input  opbc_pkg::opbc_op_t q_data_i,
  output logic               pop_o,
  output logic               clear_busy_o,
  opbc_out_if.source         out_o
);
  import opbc_pkg::*;

  `include "assert_macros.svh"

  logic [7:0]       store_q [StoreBytes];
  logic [AddrW-1:0] clr_addr_q;
  logic             clearing_q;
  logic             res_valid_q;
  opbc_op_t         res_q;
  logic [7:0]       rdata_q;

  assign clear_busy_o = clearing_q;
  assign pop_o = q_valid_i && !clearing_q && (!res_valid_q || out_o.ready);

  // zero the whole store once after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clearing_q <= 1'b1;
      clr_addr_q <= '0;
    end else if (clearing_q) begin
      clr_addr_q <= clr_addr_q + 1'b1;
      if (clr_addr_q == AddrW'(StoreBytes - 1)) begin
        clearing_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (clearing_q) begin
      store_q[clr_addr_q] <= 8'h00;
    end else if (pop_o && q_data_i.wr_en) begin
      store_q[q_data_i.addr] <= q_data_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && q_data_i.is_read) begin
      rdata_q <= store_q[q_data_i.addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      res_q <= q_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (pop_o) begin
      res_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  assign out_o.valid           = res_valid_q;
  assign out_o.pixel_lit       = res_q.is_read && res_q.rd_ok && res_q.disp &&
                                 (rdata_q[res_q.bit_sel] ^ res_q.inv);
  assign out_o.display_enabled = res_q.disp;
  assign out_o.colors_inverted = res_q.inv;
  assign out_o.redraw_request  = res_q.redraw;
  assign out_o.unknown_command = res_q.unknown;

  `ASSERT_AT(a_no_pop_while_clearing, clk_i, rst_ni, clearing_q |-> !pop_o)
  `ASSERT_AT(a_result_held_on_stall, clk_i, rst_ni,
             (res_valid_q && !out_o.ready) |=> (res_valid_q && $stable(res_q)))

endmodule

// ----- rtl/oled_page_buffer_controller_unit.sv -----
// ----------------------------------------------------------------------------
// oled_page_buffer_controller_unit
// receive side of a monochrome page-organized display controller
// ----------------------------------------------------------------------------
// Takes one word per cycle while the queue has room and no sweep runs,
// and gives one result word per word, in order. Stream bytes run through a
// control/command/data parser; data chunks land in a 1024-byte
// page-organized frame store, and pixel reads look up one bit of it. A word
// is accepted into a two-entry queue and leaves through the output register;
// the single store port serves one write or one read per cycle, which sets
// the rate of one word per cycle. After reset the store is swept to zero,
// one byte a cycle, so in_i.ready stays low until the sweep is done.
module oled_page_buffer_controller_unit (
  input  logic clk_i,
  input  logic rst_ni,
  opbc_in_if.sink    in_i,
  opbc_out_if.source out_o
);
  import opbc_pkg::*;

  logic     push;
  logic     pop;
  logic     q_full;
  logic     q_valid;
  logic     clear_busy;
  opbc_op_t push_data;
  opbc_op_t pop_data;

  opbc_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .clear_busy_i (clear_busy),
    .q_full_i     (q_full),
    .push_o       (push),
    .push_data_o  (push_data)
  );

  opbc_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (q_full),
    .pop_i       (pop),
    .valid_o     (q_valid),
    .pop_data_o  (pop_data)
  );

  opbc_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_valid_i    (q_valid),
    .q_data_i     (pop_data),
    .pop_o        (pop),
    .clear_busy_o (clear_busy),
    .out_o        (out_o)
  );

endmodule

// ----- verif/oled_page_buffer_controller_unit_test.sv -----
// ----------------------------------------------------------------------------
// oled_page_buffer_controller_unit_test
// self-checking bench for the page buffer controller
// ----------------------------------------------------------------------------
// Drives stream byte writes and pixel reads through the input channel and
// checks every result word against a cycle-free model of the parser, the
// display flags and the frame store, or against the typed result of its
// directed row. A short table of directed words comes first, then random
// command, chunk and read sequences, half the reads aimed at written bytes.
// The sender works in bursts and the receiver stalls on its own pattern,
// with one long receiver hold-off and a full drain mid-run and at the end.
module oled_page_buffer_controller_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import opbc_pkg::*;

  localparam logic       MODE_WR   = 1'b0;
  localparam logic       MODE_RD   = 1'b1;
  localparam logic [7:0] CTRL_CMD  = 8'h00;
  localparam logic [7:0] CTRL_DATA = 8'h40;
  localparam logic [7:0] CMD_OFF    = 8'hAE;
  localparam logic [7:0] CMD_ON     = 8'hAF;
  localparam logic [7:0] CMD_NORMAL = 8'hA6;
  localparam logic [7:0] CMD_INVERT = 8'hA7;
  localparam logic [7:0] CMD_NOP    = 8'hE3;

  localparam int WatchdogLimit = 4000;
  localparam int HoldCycles    = 80;
  localparam int MixWords      = 360;
  localparam int ReportMax     = 10;

  typedef enum logic [1:0] {
    ExpectCtrl,
    ExpectCmd,
    ExpectData
  } parse_phase_e;

  typedef struct packed {
    logic       mode;
    logic [7:0] sbyte;
    logic [6:0] col;
    logic [5:0] row;
  } word_t;

  typedef struct packed {
    logic lit;
    logic disp;
    logic inv;
    logic redraw;
    logic unknown;
  } pix_result_t;

  typedef struct {
    word_t       w;
    bit          typed;
    pix_result_t res;
  } dir_row_t;

  logic clk_i;
  logic rst_ni;

  opbc_in_if  in_ch ();
  opbc_out_if out_ch ();

  oled_page_buffer_controller_unit u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch),
    .out_o (out_ch)
  );

  // model state
  parse_phase_e phase_q;
  int           byte_cnt;
  int           chunk_idx;
  logic         disp_q;
  logic         inv_q;
  logic [7:0]   frame_shadow [StoreBytes];
  int           hiwater;

  pix_result_t  pixel_expect_q [$];

  // run statistics
  int n_words, n_reads, n_lit, n_cmds, n_unknown, n_chunks, n_wraps;
  int n_errors, n_reported;

  // sender and receiver pacing
  int burst_left;
  int rx_cycle;
  int rx_style;
  int hold_left;
  bit hold_pending;
  int stall_cycles;

  // result columns: lit, disp, inv, redraw, unknown
  localparam int DirRows = 25;
  dir_row_t dir_tab [DirRows] = '{
    '{'{MODE_RD, 8'h00,      7'd0,   6'd0},  1'b1, 5'b00000},
    '{'{MODE_RD, 8'hFF,      7'd127, 6'd63}, 1'b1, 5'b00000},
    '{'{MODE_WR, CTRL_CMD,   7'd0,   6'd0},  1'b1, 5'b00000},
    '{'{MODE_WR, CMD_OFF,    7'd127, 6'd63}, 1'b1, 5'b00010},
    '{'{MODE_WR, CTRL_CMD,   7'd0,   6'd0},  1'b1, 5'b00000},
    '{'{MODE_WR, CMD_ON,     7'd0,   6'd0},  1'b1, 5'b01010},
    '{'{MODE_WR, CTRL_CMD,   7'd0,   6'd0},  1'b1, 5'b01000},
    '{'{MODE_WR, 8'h5A,      7'd0,   6'd0},  1'b1, 5'b01001},
    '{'{MODE_WR, CTRL_CMD,   7'd0,   6'd0},  1'b1, 5'b01000},
    '{'{MODE_WR, CMD_NOP,    7'd0,   6'd0},  1'b1, 5'b01000},
    '{'{MODE_RD, 8'h00,      7'd64,  6'd32}, 1'b1, 5'b01000},
    '{'{MODE_WR, CTRL_CMD,   7'd0,   6'd0},  1'b1, 5'b01000},
    '{'{MODE_WR, CMD_INVERT, 7'd0,   6'd0},  1'b1, 5'b01110},
    '{'{MODE_RD, 8'h00,      7'd127, 6'd63}, 1'b1, 5'b11100},
    '{'{MODE_WR, CTRL_CMD,   7'd0,   6'd0},  1'b1, 5'b01100},
    '{'{MODE_WR, CMD_INVERT, 7'd0,   6'd0},  1'b1, 5'b01110},
    '{'{MODE_WR, CTRL_CMD,   7'd0,   6'd0},  1'b1, 5'b01100},
    '{'{MODE_WR, CMD_NORMAL, 7'd0,   6'd0},  1'b1, 5'b01010},
    '{'{MODE_WR, 8'h41,      7'd0,   6'd0},  1'b1, 5'b01000},
    '{'{MODE_WR, CTRL_DATA,  7'd0,   6'd0},  1'b1, 5'b01000},
    '{'{MODE_WR, 8'hFF,      7'd0,   6'd0},  1'b0, 5'b00000},
    '{'{MODE_RD, 8'hFF,      7'd0,   6'd0},  1'b0, 5'b00000},
    '{'{MODE_WR, CTRL_CMD,   7'd0,   6'd0},  1'b0, 5'b00000},
    '{'{MODE_WR, 8'h81,      7'd0,   6'd0},  1'b0, 5'b00000},
    '{'{MODE_RD, 8'h00,      7'd1,   6'd7},  1'b0, 5'b00000}
  };

  always #5ns clk_i = ~clk_i;

  function automatic pix_result_t predict_pixel_word(word_t w);
    pix_result_t r;
    int          addr;
    logic        stored;
    r = '0;
    if (w.mode == MODE_RD) begin
      n_reads++;
      if (int'(w.col) < PanelWidth) begin
        addr = int'(w.row >> 3) * PanelWidth + int'(w.col);
        if (addr < StoreBytes) begin
          stored = frame_shadow[addr][w.row[2:0]];
          r.lit  = disp_q & (stored ^ inv_q);
        end
      end
      n_lit += r.lit;
    end else begin
      case (phase_q)
        ExpectCmd: begin
          phase_q = ExpectCtrl;
          n_cmds++;
          case (w.sbyte)
            CMD_OFF: begin
              disp_q   = 1'b0;
              r.redraw = 1'b1;
            end
            CMD_ON: begin
              disp_q   = 1'b1;
              r.redraw = 1'b1;
            end
            CMD_NORMAL: begin
              inv_q    = 1'b0;
              r.redraw = 1'b1;
            end
            CMD_INVERT: begin
              inv_q    = 1'b1;
              r.redraw = 1'b1;
            end
            CMD_NOP: begin
            end
            default: begin
              r.unknown = 1'b1;
              n_unknown++;
            end
          endcase
        end
        ExpectData: begin
          addr = chunk_idx * ChunkBytes + byte_cnt;
          if (addr < StoreBytes) begin
            frame_shadow[addr] = w.sbyte;
            if (addr >= hiwater) hiwater = addr + 1;
          end
          byte_cnt++;
          if (byte_cnt >= ChunkBytes) begin
            byte_cnt = 0;
            phase_q  = ExpectCtrl;
            n_chunks++;
            chunk_idx++;
            // last chunk of the frame wraps and asks for a redraw
            if (chunk_idx >= ChunkCount) begin
              chunk_idx = 0;
              r.redraw  = 1'b1;
              n_wraps++;
            end
          end
        end
        default: begin
          phase_q = ExpectCtrl;
          if (w.sbyte == CTRL_CMD) begin
            phase_q = ExpectCmd;
          end else if (w.sbyte == CTRL_DATA) begin
            phase_q  = ExpectData;
            byte_cnt = 0;
          end
        end
      endcase
    end
    r.disp = disp_q;
    r.inv  = inv_q;
    return r;
  endfunction

  task automatic send_word(input word_t w, input bit typed, input pix_result_t typed_res);
    pix_result_t r;
    int          gap;
    @(negedge clk_i);
    in_ch.valid        <= 1'b1;
    in_ch.mode         <= w.mode;
    in_ch.stream_byte  <= w.sbyte;
    in_ch.pixel_column <= w.col;
    in_ch.pixel_row    <= w.row;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    r = predict_pixel_word(w);
    pixel_expect_q.push_back(typed ? typed_res : r);
    n_words++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap        = $urandom_range(1, 6);
      burst_left = ($urandom_range(0, 9) == 0) ? 60 : $urandom_range(0, 24);
      @(negedge clk_i);
      in_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
  endtask

  task automatic send_rand(input logic mode, input logic [7:0] sbyte);
    word_t w;
    w.mode  = mode;
    w.sbyte = sbyte;
    w.col   = 7'($urandom_range(0, 127));
    w.row   = 6'($urandom_range(0, 63));
    send_word(w, 1'b0, '0);
  endtask

  // half the reads land on bytes already written, the rest anywhere
  task automatic send_read();
    word_t w;
    int    addr;
    w.mode  = MODE_RD;
    w.sbyte = 8'($urandom_range(0, 255));
    w.col   = 7'($urandom_range(0, 127));
    w.row   = 6'($urandom_range(0, 63));
    if (hiwater > 0 && $urandom_range(0, 1) == 1) begin
      addr  = $urandom_range(0, hiwater - 1);
      w.col = 7'(addr % PanelWidth);
      w.row = 6'((addr / PanelWidth) * 8 + $urandom_range(0, 7));
    end
    send_word(w, 1'b0, '0);
  endtask

  task automatic send_chunk(inout int cnt);
    send_rand(MODE_WR, CTRL_DATA);
    cnt++;
    for (int i = 0; i < ChunkBytes; i++) begin
      if ($urandom_range(0, 9) == 0) begin
        send_read();
        cnt++;
      end
      send_rand(MODE_WR, 8'($urandom_range(0, 255)));
      cnt++;
    end
  endtask

  task automatic send_cmd(inout int cnt);
    logic [7:0] code;
    int         pick;
    pick = $urandom_range(0, 99);
    if (pick < 35)      code = CMD_ON;
    else if (pick < 45) code = CMD_OFF;
    else if (pick < 60) code = CMD_NORMAL;
    else if (pick < 75) code = CMD_INVERT;
    else if (pick < 85) code = CMD_NOP;
    else                code = 8'($urandom_range(0, 255));
    send_rand(MODE_WR, CTRL_CMD);
    send_rand(MODE_WR, code);
    cnt += 2;
  endtask

  task automatic run_mix(input int target);
    int cnt;
    int pick;
    cnt = 0;
    while (cnt < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        send_chunk(cnt);
      end else if (pick < 65) begin
        send_cmd(cnt);
      end else if (pick < 90) begin
        send_read();
        cnt++;
      end else begin
        // stray byte: may be ignored or may start a broken sequence
        send_rand(MODE_WR, 8'($urandom_range(0, 255)));
      end
    end
  endtask

  task automatic drain_results();
    @(negedge clk_i);
    in_ch.valid <= 1'b0;
    while (pixel_expect_q.size() != 0) @(posedge clk_i);
  endtask

  // receiver: changes its stall style now and then, plus a long hold on request
  always @(negedge clk_i) begin
    rx_cycle++;
    if (rx_cycle % 256 == 0) rx_style = $urandom_range(0, 2);
    if (hold_pending) begin
      hold_left    = HoldCycles;
      hold_pending = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else begin
      case (rx_style)
        0:       out_ch.ready <= 1'b1;
        1:       out_ch.ready <= ($urandom_range(0, 2) != 0);
        default: out_ch.ready <= (rx_cycle % 7 > 1);
      endcase
    end
  end

  always @(posedge clk_i) begin
    pix_result_t e;
    pix_result_t a;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      a = '{out_ch.pixel_lit, out_ch.display_enabled, out_ch.colors_inverted,
            out_ch.redraw_request, out_ch.unknown_command};
      if (pixel_expect_q.size() == 0) begin
        n_errors++;
        if (n_reported < ReportMax) begin
          n_reported++;
          $display("unexpected result word: lit=%b on=%b inv=%b redraw=%b unk=%b",
                   a.lit, a.disp, a.inv, a.redraw, a.unknown);
        end
      end else begin
        e = pixel_expect_q.pop_front();
        if (a !== e) begin
          n_errors++;
          if (n_reported < ReportMax) begin
            n_reported++;
            $display("mismatch at %0t: expected lit=%b on=%b inv=%b redraw=%b unk=%b",
                     $realtime, e.lit, e.disp, e.inv, e.redraw, e.unknown);
            $display("                 got      lit=%b on=%b inv=%b redraw=%b unk=%b",
                     a.lit, a.disp, a.inv, a.redraw, a.unknown);
          end
        end
      end
    end
  end

  // watchdog: no word moving on either side for too long
  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
    end
    if (stall_cycles >= WatchdogLimit) begin
      $display("timeout after %0d idle cycles", stall_cycles);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    clk_i              = 1'b0;
    rst_ni             = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.mode         = MODE_WR;
    in_ch.stream_byte  = 8'h00;
    in_ch.pixel_column = 7'd0;
    in_ch.pixel_row    = 6'd0;
    out_ch.ready       = 1'b0;
    phase_q            = ExpectCtrl;
    byte_cnt           = 0;
    chunk_idx          = 0;
    disp_q             = 1'b0;
    inv_q              = 1'b0;
    hiwater            = 0;
    for (int i = 0; i < StoreBytes; i++) frame_shadow[i] = 8'h00;
    burst_left   = 0;
    rx_cycle     = 0;
    rx_style     = 0;
    hold_left    = 0;
    hold_pending = 1'b0;
    stall_cycles = 0;
    n_words = 0; n_reads = 0; n_lit = 0; n_cmds = 0; n_unknown = 0;
    n_chunks = 0; n_wraps = 0; n_errors = 0; n_reported = 0;

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    for (int i = 0; i < DirRows; i++) send_word(dir_tab[i].w, dir_tab[i].typed, dir_tab[i].res);

    run_mix(MixWords / 3);
    // long receiver hold while the sender keeps offering words
    hold_pending = 1'b1;
    run_mix(MixWords / 3);
    drain_results();
    run_mix(MixWords / 3);

    drain_results();
    repeat (10) @(posedge clk_i);
    n_errors += pixel_expect_q.size();

    $display("ran %0d words: %0d pixel reads (%0d lit), %0d commands (%0d unknown)",
             n_words, n_reads, n_lit, n_cmds, n_unknown);
    $display("wrote %0d data chunks, frame wrapped %0d time(s), %0d mismatches",
             n_chunks, n_wraps, n_errors);
    if (n_errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
